[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// combinational or overlapping property, checked every clock
`define HBD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// antecedent this cycle, consequent in the next
`define HBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define HBD_ASSERT(lbl, clk, rst_n, prop)
`define HBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/hbd_pkg.sv]
// ----------------------------------------------------------------------------
// hbd_pkg
// Types and constants for the complex half-band decimator.
// ----------------------------------------------------------------------------
package hbd_pkg;

	localparam int COEF_BITS    = 18;
	localparam int NUM_COEFS    = 5;
	localparam int NUM_SIDES    = 4;
	localparam int ROUND_SHIFT  = 17;
	localparam int CFG_IDX_BITS = 3;

	// distance from center served by coefficient register k+1
	localparam int SIDE_DIST [NUM_SIDES] = '{7, 5, 3, 1};

	typedef logic signed [COEF_BITS-1:0] coef_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_COEF_CENTER = 3'd0,
		REG_COEF_DIST7  = 3'd1,
		REG_COEF_DIST5  = 3'd2,
		REG_COEF_DIST3  = 3'd3,
		REG_COEF_DIST1  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_ctl_t;

endpackage

[hdl/complex_halfband_decimator_top.sv]
// ----------------------------------------------------------------------------
// complex_halfband_decimator_top
// Complex half-band FIR decimator by two, built as a chain of tap cells.
// Throughput: one item per cycle when not stalled; one result per two items.
// Pipeline: the last item loads s1 (pre-add), then s2, s3 and s4 (result).
// First result follows item CENTER (item 7 at 15 taps), then every second item.
// Reset: async active low; delay line, coefficients and counters clear to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module complex_halfband_decimator_top import hbd_pkg::*; #(
	parameter  int NUM_TAPS    = 15,
	parameter  int SAMPLE_BITS = 16,
	localparam int DATA_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [DATA_W-1:0]       s_axis_tdata,  // in_i, in_q, zero pad
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [DATA_W-1:0]       m_axis_tdata,  // out_i, out_q, zero pad
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COEF_BITS-1:0]    cfg_data
);

	localparam int CENTER     = (NUM_TAPS - 1) / 2;
	localparam int CNT_W      = $clog2(CENTER + 1);
	localparam logic CENTER_PAR = 1'(CENTER % 2);

	coef_t coef_q [NUM_COEFS];

	logic signed [SAMPLE_BITS-1:0] line_i [NUM_TAPS];
	logic signed [SAMPLE_BITS-1:0] line_q [NUM_TAPS];
	logic signed [SAMPLE_BITS-1:0] side_a_i [NUM_SIDES];
	logic signed [SAMPLE_BITS-1:0] side_b_i [NUM_SIDES];
	logic signed [SAMPLE_BITS-1:0] side_a_q [NUM_SIDES];
	logic signed [SAMPLE_BITS-1:0] side_b_q [NUM_SIDES];
	logic signed [SAMPLE_BITS-1:0] out_i;
	logic signed [SAMPLE_BITS-1:0] out_q;

	logic [CNT_W-1:0] startup_q;
	logic             phase_q;
	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	logic             rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic             in_acc;
	logic             emit_w;
	pipe_ctl_t        ctl;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_COEFS; j++) begin
				coef_q[j] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COEF_CENTER: coef_q[0] <= cfg_data;
				REG_COEF_DIST7:  coef_q[1] <= cfg_data;
				REG_COEF_DIST5:  coef_q[2] <= cfg_data;
				REG_COEF_DIST3:  coef_q[3] <= cfg_data;
				REG_COEF_DIST1:  coef_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign rdy_s4 = !valid_s4 || m_axis_tready;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;

	assign s_axis_tready = rdy_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign emit_w        = (startup_q == CNT_W'(CENTER)) && (phase_q == CENTER_PAR);

	assign ctl.en_s1 = in_acc && emit_w;
	assign ctl.en_s2 = rdy_s2 && valid_s1;
	assign ctl.en_s3 = rdy_s3 && valid_s2;
	assign ctl.en_s4 = rdy_s4 && valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_q <= '0;
			phase_q   <= 1'b0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
		end else begin
			if (in_acc) begin
				if (startup_q != CNT_W'(CENTER)) begin
					startup_q <= startup_q + 1'b1;
				end
				phase_q <= ~phase_q;
			end
			if (rdy_s1) valid_s1 <= in_acc && emit_w;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	assign m_axis_tvalid = valid_s4;

	// delay line: line[0] is the arriving sample, line[k] the k-th older one
	assign line_i[0] = s_axis_tdata[SAMPLE_BITS-1:0];
	assign line_q[0] = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

	for (genvar k = 0; k < NUM_TAPS - 1; k++) begin : g_cell
		hbd_tap_cell #(
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (in_acc),
			.d_i      (line_i[k]),
			.d_q      (line_q[k]),
			.q_i      (line_i[k+1]),
			.q_q      (line_q[k+1])
		);
	end

	// tap pairs around the center; distances past the center weigh zero
	for (genvar k = 0; k < NUM_SIDES; k++) begin : g_side
		localparam int D = SIDE_DIST[k];
		if (D <= CENTER) begin : g_used
			assign side_a_i[k] = line_i[CENTER-D];
			assign side_b_i[k] = line_i[CENTER+D];
			assign side_a_q[k] = line_q[CENTER-D];
			assign side_b_q[k] = line_q[CENTER+D];
		end else begin : g_unused
			assign side_a_i[k] = '0;
			assign side_b_i[k] = '0;
			assign side_a_q[k] = '0;
			assign side_b_q[k] = '0;
		end
	end

	hbd_lane #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_i (
		.clk    (clk),
		.ctl    (ctl),
		.coef   (coef_q),
		.center (line_i[CENTER]),
		.side_a (side_a_i),
		.side_b (side_b_i),
		.result (out_i)
	);

	hbd_lane #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_q (
		.clk    (clk),
		.ctl    (ctl),
		.coef   (coef_q),
		.center (line_q[CENTER]),
		.side_a (side_a_q),
		.side_b (side_b_q),
		.result (out_q)
	);

	assign m_axis_tdata = DATA_W'({out_q, out_i});

	`HBD_ASSERT(a_startup_sat, clk, arst_n, startup_q <= CNT_W'(CENTER))
	`HBD_ASSERT_NEXT(a_emit_alternates, clk, arst_n, in_acc && emit_w, !emit_w)
	`HBD_ASSERT(a_s1_from_emit, clk, arst_n, $rose(valid_s1) |-> $past(in_acc && emit_w))
	`HBD_ASSERT(a_stall_only_full, clk, arst_n, !s_axis_tready |-> (valid_s1 && valid_s4))

endmodule

[hdl/hbd_tap_cell.sv]
// ----------------------------------------------------------------------------
// hbd_tap_cell
// One delay-line cell: holds one complex sample, passes it on each shift.
// ----------------------------------------------------------------------------
module hbd_tap_cell #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift_en,
	input  logic signed [SAMPLE_BITS-1:0] d_i,
	input  logic signed [SAMPLE_BITS-1:0] d_q,
	output logic signed [SAMPLE_BITS-1:0] q_i,
	output logic signed [SAMPLE_BITS-1:0] q_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_i <= '0;
			q_q <= '0;
		end else if (shift_en) begin
			q_i <= d_i;
			q_q <= d_q;
		end
	end

endmodule

[hdl/hbd_lane.sv]
// ----------------------------------------------------------------------------
// hbd_lane
// One real lane of the filter: pre-add, multiply, add tree, round, saturate.
// ----------------------------------------------------------------------------
module hbd_lane import hbd_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  pipe_ctl_t                     ctl,
	input  coef_t                         coef   [NUM_COEFS],
	input  logic signed [SAMPLE_BITS-1:0] center,
	input  logic signed [SAMPLE_BITS-1:0] side_a [NUM_SIDES],
	input  logic signed [SAMPLE_BITS-1:0] side_b [NUM_SIDES],
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int SUM_W  = SAMPLE_BITS + 1;
	localparam int PW     = COEF_BITS + SUM_W;
	localparam int PART_W = PW + 1;
	localparam int ACC_W  = PW + 3;

	localparam logic signed [ACC_W-1:0] RND_C   = ACC_W'(1) << (ROUND_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

	logic signed [SAMPLE_BITS-1:0] center_s1;
	logic signed [SUM_W-1:0]       sum_s1  [NUM_SIDES];
	logic signed [PW-1:0]          prod_s2 [NUM_COEFS];
	logic signed [PART_W-1:0]      part_s3 [3];

	logic signed [PW-1:0]          coef_x  [NUM_COEFS];
	logic signed [PW-1:0]          smp_x   [NUM_COEFS];
	logic signed [ACC_W-1:0]       acc_w;
	logic signed [ACC_W-1:0]       shr_w;
	logic signed [SAMPLE_BITS-1:0] sat_w;

	// stage 1: symmetric pre-add
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			center_s1 <= center;
			for (int j = 0; j < NUM_SIDES; j++) begin
				sum_s1[j] <= $signed({side_a[j][SAMPLE_BITS-1], side_a[j]})
					+ $signed({side_b[j][SAMPLE_BITS-1], side_b[j]});
			end
		end
	end

	// stage 2: one multiplier per coefficient
	always_comb begin
		smp_x[0] = {{(PW-SAMPLE_BITS){center_s1[SAMPLE_BITS-1]}}, center_s1};
		for (int j = 0; j < NUM_SIDES; j++) begin
			smp_x[j+1] = {{(PW-SUM_W){sum_s1[j][SUM_W-1]}}, sum_s1[j]};
		end
		for (int j = 0; j < NUM_COEFS; j++) begin
			coef_x[j] = {{(PW-COEF_BITS){coef[j][COEF_BITS-1]}}, coef[j]};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			for (int j = 0; j < NUM_COEFS; j++) begin
				prod_s2[j] <= coef_x[j] * smp_x[j];
			end
		end
	end

	// stage 3: first level of the add tree
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			part_s3[0] <= $signed({prod_s2[0][PW-1], prod_s2[0]})
				+ $signed({prod_s2[1][PW-1], prod_s2[1]});
			part_s3[1] <= $signed({prod_s2[2][PW-1], prod_s2[2]})
				+ $signed({prod_s2[3][PW-1], prod_s2[3]});
			part_s3[2] <= $signed({prod_s2[4][PW-1], prod_s2[4]});
		end
	end

	// stage 4: final add, round half up, saturate
	always_comb begin
		acc_w = $signed({{2{part_s3[0][PART_W-1]}}, part_s3[0]})
			+ $signed({{2{part_s3[1][PART_W-1]}}, part_s3[1]})
			+ $signed({{2{part_s3[2][PART_W-1]}}, part_s3[2]})
			+ RND_C;
		shr_w = acc_w >>> ROUND_SHIFT;
		if (shr_w > SAT_MAX) begin
			sat_w = SAT_MAX[SAMPLE_BITS-1:0];
		end else if (shr_w < SAT_MIN) begin
			sat_w = SAT_MIN[SAMPLE_BITS-1:0];
		end else begin
			sat_w = shr_w[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			result <= sat_w;
		end
	end

endmodule
